@@ sv/nccs_pkg.sv @@
// Shared types and constants for the nested comment and command scanner.
// Holds the phase encoding, result codes, character codes and item structs.
// No dependencies.
package nccs_pkg;

   localparam int CH_W        = 21;
   localparam int REQ_DATA_W  = 24;
   localparam int REQ_USER_W  = 4;
   localparam int RSP_DATA_W  = 8;

   typedef enum logic [10:0] {
      PH_IDLE   = 11'b000_0000_0001,
      PH_WS     = 11'b000_0000_0010,
      PH_OPEN   = 11'b000_0000_0100,
      PH_BODY   = 11'b000_0000_1000,
      PH_BSLASH = 11'b000_0001_0000,
      PH_BSTAR  = 11'b000_0010_0000,
      PH_CMD    = 11'b000_0100_0000,
      PH_DQ     = 11'b000_1000_0000,
      PH_DQESC  = 11'b001_0000_0000,
      PH_SQ     = 11'b010_0000_0000,
      PH_SQESC  = 11'b100_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_SKIP = 2'd1,
      ACT_TAKE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_CONT = 2'd0,
      ST_ACC  = 2'd1,
      ST_REJ  = 2'd2,
      ST_OVF  = 2'd3
   } status_type;

   localparam logic KIND_COMMENT = 1'b0;
   localparam logic KIND_COMMAND = 1'b1;

   localparam logic [CH_W-1:0] CH_SLASH  = 21'h2F;
   localparam logic [CH_W-1:0] CH_STAR   = 21'h2A;
   localparam logic [CH_W-1:0] CH_LPAREN = 21'h28;
   localparam logic [CH_W-1:0] CH_RPAREN = 21'h29;
   localparam logic [CH_W-1:0] CH_SPACE  = 21'h20;
   localparam logic [CH_W-1:0] CH_TAB    = 21'h09;
   localparam logic [CH_W-1:0] CH_LF     = 21'h0A;
   localparam logic [CH_W-1:0] CH_CR     = 21'h0D;
   localparam logic [CH_W-1:0] CH_DQUOTE = 21'h22;
   localparam logic [CH_W-1:0] CH_SQUOTE = 21'h27;
   localparam logic [CH_W-1:0] CH_BSLASH = 21'h5C;

   typedef struct packed {
      logic            start_req;
      logic            error_recovery;
      logic            want_command;
      logic            want_comment;
      logic [CH_W-1:0] ch;
      logic            at_eof;
   } item_type;

   typedef struct packed {
      action_type action;
      status_type status;
      logic       token_kind;
   } result_type;

endpackage

@@ sv/nccs_in_reg.sv @@
// Input register of the scanner: holds one accepted request.
// Depends on nccs_pkg for the item struct.
module nccs_in_reg
   import nccs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  item_type load_item,
   input  logic     drain,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   // load wins over drain: a new request replaces the one moving on
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ sv/nccs_scan.sv @@
// Scan state and next-state logic: phase machine plus comment depth, paren depth and content flag.
// Depends on nccs_pkg for phase, result codes and character constants.
module nccs_scan
   import nccs_pkg::*;
#(
   parameter int MAX_NEST = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   localparam int DW = $clog2(MAX_NEST + 1);
   localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NEST);

   phase_type     phase_ff, phase_in;
   logic [DW-1:0] cdepth_ff, cdepth_in;
   logic [DW-1:0] pdepth_ff, pdepth_in;
   logic          has_ff, has_in;

   always_comb begin
      phase_type       cur;
      logic [DW-1:0]   cd;
      logic [DW-1:0]   pd;
      logic [DW-1:0]   dec;
      logic            hc;
      logic            eof;
      logic [CH_W-1:0] c;
      logic            do_body;
      logic            is_ws;

      cur     = phase_ff;
      cd      = cdepth_ff;
      pd      = pdepth_ff;
      hc      = has_ff;
      eof     = item.at_eof;
      c       = eof ? '0 : item.ch;
      do_body = 1'b0;
      dec     = '0;
      is_ws   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);

      // a start aborts any scan and picks the path: recovery, command, comment
      if (item.start_req) begin
         cd = '0;
         pd = '0;
         hc = 1'b0;
         if (item.error_recovery) begin
            cur = PH_WS;
         end else if (item.want_command) begin
            cur = PH_CMD;
         end else if (item.want_comment) begin
            cur = PH_WS;
         end else begin
            cur = PH_IDLE;
         end
      end

      result.action     = ACT_NONE;
      result.status     = ST_REJ;
      result.token_kind = KIND_COMMENT;
      phase_in          = cur;
      cdepth_in         = cd;
      pdepth_in         = pd;
      has_in            = hc;

      case (cur)
         PH_WS: begin
            if (!eof && is_ws) begin
               result.action = ACT_SKIP;
               result.status = ST_CONT;
            end else if (!eof && c == CH_SLASH) begin
               phase_in      = PH_OPEN;
               result.action = ACT_TAKE;
               result.status = ST_CONT;
            end
         end
         PH_OPEN: begin
            if (!eof && c == CH_STAR) begin
               cdepth_in     = DW'(1);
               phase_in      = PH_BODY;
               result.action = ACT_TAKE;
               result.status = ST_CONT;
            end
         end
         PH_BODY: begin
            do_body = 1'b1;
         end
         PH_BSLASH: begin
            if (!eof && c == CH_STAR) begin
               result.action = ACT_TAKE;
               if (cd >= DEPTH_MAX) begin
                  result.status = ST_OVF;
               end else begin
                  cdepth_in     = cd + DW'(1);
                  phase_in      = PH_BODY;
                  result.status = ST_CONT;
               end
            end else begin
               do_body = 1'b1;
            end
         end
         PH_BSTAR: begin
            if (!eof && c == CH_SLASH) begin
               dec           = (cd != '0) ? cd - DW'(1) : cd;
               cdepth_in     = dec;
               result.action = ACT_TAKE;
               if (dec == '0) begin
                  result.status     = ST_ACC;
                  result.token_kind = KIND_COMMENT;
               end else begin
                  phase_in      = PH_BODY;
                  result.status = ST_CONT;
               end
            end else begin
               do_body = 1'b1;
            end
         end
         PH_CMD: begin
            if (eof || (c == CH_RPAREN && pd == '0)) begin
               if (hc) begin
                  result.status     = ST_ACC;
                  result.token_kind = KIND_COMMAND;
               end
            end else begin
               has_in        = 1'b1;
               result.action = ACT_TAKE;
               result.status = ST_CONT;
               if (c == CH_LPAREN) begin
                  if (pd >= DEPTH_MAX) begin
                     result.status = ST_OVF;
                  end else begin
                     pdepth_in = pd + DW'(1);
                  end
               end else if (c == CH_RPAREN) begin
                  pdepth_in = pd - DW'(1);
               end else if (c == CH_DQUOTE) begin
                  phase_in = PH_DQ;
               end else if (c == CH_SQUOTE) begin
                  phase_in = PH_SQ;
               end
            end
         end
         PH_DQ, PH_SQ: begin
            if (eof) begin
               result.status     = ST_ACC;
               result.token_kind = KIND_COMMAND;
            end else begin
               result.action = ACT_TAKE;
               result.status = ST_CONT;
               if (c == ((cur == PH_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
                  phase_in = PH_CMD;
               end else if (c == CH_BSLASH) begin
                  phase_in = (cur == PH_DQ) ? PH_DQESC : PH_SQESC;
               end
            end
         end
         PH_DQESC, PH_SQESC: begin
            if (eof) begin
               result.status     = ST_ACC;
               result.token_kind = KIND_COMMAND;
            end else begin
               phase_in      = (cur == PH_DQESC) ? PH_DQ : PH_SQ;
               result.action = ACT_TAKE;
               result.status = ST_CONT;
            end
         end
         default: begin
            result.status = ST_REJ;
         end
      endcase

      // plain comment body character, also the fall-back after a pending mark
      if (do_body) begin
         if (eof) begin
            result.action = ACT_NONE;
            result.status = ST_REJ;
         end else begin
            result.action = ACT_TAKE;
            result.status = ST_CONT;
            if (c == CH_SLASH) begin
               phase_in = PH_BSLASH;
            end else if (c == CH_STAR) begin
               phase_in = PH_BSTAR;
            end else begin
               phase_in = PH_BODY;
            end
         end
      end

      if (result.status != ST_CONT) begin
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cdepth_ff <= '0;
         pdepth_ff <= '0;
         has_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         cdepth_ff <= cdepth_in;
         pdepth_ff <= pdepth_in;
         has_ff    <= has_in;
      end
   end

endmodule

@@ sv/nccs_out_reg.sv @@
// Output register of the scanner: holds one result until the receiver takes it.
// Depends on nccs_pkg for the result struct.
module nccs_out_reg
   import nccs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_result,
   input  logic       taken,
   output logic       result_valid,
   output result_type result
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (taken) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

   assign result_valid = valid_ff;
   assign result       = result_ff;

endmodule

@@ sv/nested_comment_and_command_scanner.sv @@
// Nested block comment and command content scanner, top level.
// Depends on nccs_pkg, nccs_in_reg, nccs_scan and nccs_out_reg.
//
// Usage:
//   The request channel (req_) carries one lookahead character per request,
//   with the start and token-choice flags in req_tuser and end of input on
//   req_tlast. A request with start_req set begins a fresh scan and is
//   itself scanned. The response channel (rsp_) returns exactly one result
//   per request: the action taken on the character, the scan status and,
//   on accept, the token kind in rsp_tuser.
//   Path: an accepted request moves from the input register to the result
//   register, which drives rsp_.
//   Throughput: one request per cycle, sustained while rsp_tready stays
//   high; the phase machine and the depth counters update in the same cycle
//   that a request moves from the input register to the result register.
//   Stall: while rsp_tready is low and a result waits, the held request
//   stays in the input register; req_tready drops only when both stages are
//   full, and rises again in the cycle the receiver takes the result.
//   Reset: synchronous, active high; both stages empty, phase idle, depths
//   and the content flag cleared. An item without start while idle rejects.
module nested_comment_and_command_scanner
   import nccs_pkg::*;
#(
   parameter int MAX_NEST = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [20:0] ch, rest zero
   input  logic [REQ_USER_W-1:0] req_tuser,  // [0] start_req, [1] error_recovery,
                                             // [2] want_command, [3] want_comment
   input  logic                  req_tlast,  // at_eof
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [1:0] action, [3:2] status, rest zero
   output logic                  rsp_tuser   // token_kind
);

   item_type   req_item;
   item_type   held_item;
   logic       held_valid;
   logic       req_accept;
   logic       advance;
   logic       rsp_valid;
   result_type step_result;
   result_type rsp_result;

   // unpack the request into the item struct
   assign req_item.start_req      = req_tuser[0];
   assign req_item.error_recovery = req_tuser[1];
   assign req_item.want_command   = req_tuser[2];
   assign req_item.want_comment   = req_tuser[3];
   assign req_item.ch             = req_tdata[CH_W-1:0];
   assign req_item.at_eof         = req_tlast;

   // advance the held request whenever the result register is free or drains
   assign advance    = held_valid && (!rsp_valid || rsp_tready);
   assign req_tready = !held_valid || advance;
   assign req_accept = req_tvalid && req_tready;

   nccs_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (req_accept),
      .load_item   (req_item),
      .drain       (advance),
      .item_valid  (held_valid),
      .item        (held_item)
   );

   // scan state moves only when the request's result is captured
   nccs_scan #(
      .MAX_NEST (MAX_NEST)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (held_item),
      .result (step_result)
   );

   nccs_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .load         (advance),
      .load_result  (step_result),
      .taken        (rsp_tready),
      .result_valid (rsp_valid),
      .result       (rsp_result)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {{(RSP_DATA_W - 4){1'b0}}, rsp_result.status, rsp_result.action};
   assign rsp_tuser  = rsp_result.token_kind;

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for nested_comment_and_command_scanner.
// Drives character requests with random gaps and stalls, and checks every response.
// Depends on nccs_pkg and the scanner RTL.
module tb;
   import nccs_pkg::*;

   localparam int MAX_NEST    = 255;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 75;

   // Tracks the expected scanner state and a FIFO of expected responses.
   class scan_scoreboard;
      phase_type   phase;
      int unsigned comment_depth;
      int unsigned paren_level;
      bit          content_seen;
      result_type  pending_verdicts[$];
      int unsigned mismatches;
      int unsigned checked;

      function new();
         phase         = PH_IDLE;
         comment_depth = 0;
         paren_level   = 0;
         content_seen  = 0;
         mismatches    = 0;
         checked       = 0;
      endfunction

      // Build a response; any final status drops the scan back to idle.
      function result_type verdict(action_type act, status_type st, logic kind);
         result_type r;
         r.action     = act;
         r.status     = st;
         r.token_kind = (st == ST_ACC) ? kind : KIND_COMMENT;
         if (st != ST_CONT)
            phase = PH_IDLE;
         return r;
      endfunction

      function bit is_blank(logic [CH_W-1:0] c);
         return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
      endfunction

      function result_type body_char(logic [CH_W-1:0] c, logic eof);
         if (eof)
            return verdict(ACT_NONE, ST_REJ, KIND_COMMENT);
         if (c == CH_SLASH)
            phase = PH_BSLASH;
         else if (c == CH_STAR)
            phase = PH_BSTAR;
         return verdict(ACT_TAKE, ST_CONT, KIND_COMMENT);
      endfunction

      function result_type quote_char(logic [CH_W-1:0] c, logic eof,
                                      logic [CH_W-1:0] quote, phase_type esc_phase);
         if (eof)
            return verdict(ACT_NONE, ST_ACC, KIND_COMMAND);
         if (c == quote)
            phase = PH_CMD;
         else if (c == CH_BSLASH)
            phase = esc_phase;
         return verdict(ACT_TAKE, ST_CONT, KIND_COMMENT);
      endfunction

      // Advance the scan by one character and return the response it causes.
      function result_type scan_char(item_type it);
         logic            eof;
         logic [CH_W-1:0] c;
         eof = it.at_eof;
         c   = eof ? '0 : it.ch;
         if (it.start_req) begin
            comment_depth = 0;
            paren_level   = 0;
            content_seen  = 0;
            if (it.error_recovery)
               phase = PH_WS;
            else if (it.want_command)
               phase = PH_CMD;
            else if (it.want_comment)
               phase = PH_WS;
            else
               phase = PH_IDLE;
            if (phase == PH_IDLE)
               return verdict(ACT_NONE, ST_REJ, KIND_COMMENT);
         end
         case (phase)
            PH_WS: begin
               if (!eof && is_blank(c))
                  return verdict(ACT_SKIP, ST_CONT, KIND_COMMENT);
               if (!eof && c == CH_SLASH) begin
                  phase = PH_OPEN;
                  return verdict(ACT_TAKE, ST_CONT, KIND_COMMENT);
               end
               return verdict(ACT_NONE, ST_REJ, KIND_COMMENT);
            end
            PH_OPEN: begin
               if (!eof && c == CH_STAR) begin
                  comment_depth = 1;
                  phase = PH_BODY;
                  return verdict(ACT_TAKE, ST_CONT, KIND_COMMENT);
               end
               return verdict(ACT_NONE, ST_REJ, KIND_COMMENT);
            end
            PH_BODY:
               return body_char(c, eof);
            PH_BSLASH: begin
               if (!eof && c == CH_STAR) begin
                  if (comment_depth >= MAX_NEST)
                     return verdict(ACT_TAKE, ST_OVF, KIND_COMMENT);
                  comment_depth++;
                  phase = PH_BODY;
                  return verdict(ACT_TAKE, ST_CONT, KIND_COMMENT);
               end
               phase = PH_BODY;
               return body_char(c, eof);
            end
            PH_BSTAR: begin
               if (!eof && c == CH_SLASH) begin
                  if (comment_depth > 0)
                     comment_depth--;
                  if (comment_depth == 0)
                     return verdict(ACT_TAKE, ST_ACC, KIND_COMMENT);
                  phase = PH_BODY;
                  return verdict(ACT_TAKE, ST_CONT, KIND_COMMENT);
               end
               phase = PH_BODY;
               return body_char(c, eof);
            end
            PH_CMD: begin
               if (eof || (c == CH_RPAREN && paren_level == 0)) begin
                  if (content_seen)
                     return verdict(ACT_NONE, ST_ACC, KIND_COMMAND);
                  return verdict(ACT_NONE, ST_REJ, KIND_COMMENT);
               end
               content_seen = 1;
               if (c == CH_LPAREN) begin
                  if (paren_level >= MAX_NEST)
                     return verdict(ACT_TAKE, ST_OVF, KIND_COMMENT);
                  paren_level++;
               end else if (c == CH_RPAREN) begin
                  paren_level--;
               end else if (c == CH_DQUOTE) begin
                  phase = PH_DQ;
               end else if (c == CH_SQUOTE) begin
                  phase = PH_SQ;
               end
               return verdict(ACT_TAKE, ST_CONT, KIND_COMMENT);
            end
            PH_DQ:
               return quote_char(c, eof, CH_DQUOTE, PH_DQESC);
            PH_SQ:
               return quote_char(c, eof, CH_SQUOTE, PH_SQESC);
            PH_DQESC, PH_SQESC: begin
               if (eof)
                  return verdict(ACT_NONE, ST_ACC, KIND_COMMAND);
               phase = (phase == PH_DQESC) ? PH_DQ : PH_SQ;
               return verdict(ACT_TAKE, ST_CONT, KIND_COMMENT);
            end
            default:
               return verdict(ACT_NONE, ST_REJ, KIND_COMMENT);
         endcase
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("MISMATCH response %0d: %s", checked, msg);
      endtask

      task note_request(item_type it);
         pending_verdicts.push_back(scan_char(it));
      endtask

      task check_result(result_type got);
         result_type want;
         if (pending_verdicts.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_verdicts.pop_front();
            if (got.action !== want.action)
               report_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.token_kind !== want.token_kind)
               report_mismatch($sformatf("token_kind %0d, want %0d",
                                         got.token_kind, want.token_kind));
         end
         checked++;
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   scan_scoreboard sb = new();

   int unsigned     send_idle_pct  = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     requests_sent  = 0;
   int unsigned     cycle_count    = 0;
   logic [CH_W-1:0] text_buf[$];

   nested_comment_and_command_scanner #(
      .MAX_NEST (MAX_NEST)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Check each response taken at this edge, then pick next cycle's ready.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(result_type'({rsp_tdata[1:0], rsp_tdata[3:2], rsp_tuser}));
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Build one request; flags only matter on a start, so randomize them elsewhere.
   function item_type char_item(bit start, bit rec, bit cmd, bit cmt,
                                logic [CH_W-1:0] ch, bit eof);
      item_type it;
      it.start_req      = start;
      it.error_recovery = start ? rec : 1'($urandom);
      it.want_command   = start ? cmd : 1'($urandom);
      it.want_comment   = start ? cmt : 1'($urandom);
      it.ch             = ch;
      it.at_eof         = eof;
      return it;
   endfunction

   // Hold the request until the block takes it, with random idle cycles ahead.
   task automatic send_request(item_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-CH_W){1'b0}}, it.ch};
      req_tuser  <= {it.want_comment, it.want_command, it.error_recovery, it.start_req};
      req_tlast  <= it.at_eof;
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
      requests_sent++;
   endtask

   // Send text_buf as one scan, optionally closed by an end-of-input request.
   task automatic send_text(bit rec, bit cmd, bit cmt, bit end_eof);
      int unsigned n;
      n = text_buf.size();
      for (int unsigned i = 0; i < n + end_eof; i++) begin
         if (i < n)
            send_request(char_item(i == 0, rec, cmd, cmt, text_buf[i], 1'b0));
         else
            send_request(char_item(i == 0, rec, cmd, cmt,
                                   CH_W'($urandom_range(0, 1114111)), 1'b1));
      end
      text_buf.delete();
   endtask

   function logic [CH_W-1:0] blank_char();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_LF;
         default: return CH_CR;
      endcase
   endfunction

   // Favor the characters the scanner reacts to; mix in aliases with high bits set.
   function logic [CH_W-1:0] pick_char();
      int unsigned     r;
      logic [CH_W-1:0] base;
      r = $urandom_range(0, 99);
      if (r < 12) return CH_SLASH;
      if (r < 24) return CH_STAR;
      if (r < 31) return CH_LPAREN;
      if (r < 38) return CH_RPAREN;
      if (r < 43) return CH_DQUOTE;
      if (r < 48) return CH_SQUOTE;
      if (r < 53) return CH_BSLASH;
      if (r < 63) return blank_char();
      if (r < 82) return CH_W'(21'h61 + $urandom_range(0, 25));
      if (r < 92) return CH_W'($urandom_range(0, 1114111));
      case ($urandom_range(0, 5))
         0:       base = CH_SLASH;
         1:       base = CH_STAR;
         2:       base = CH_LPAREN;
         3:       base = CH_RPAREN;
         4:       base = CH_DQUOTE;
         default: base = CH_SPACE;
      endcase
      return base | (CH_W'(1) << $urandom_range(8, 20));
   endfunction

   // Block comment scan: leading blanks, opener, nested body, matching closers.
   task automatic comment_run();
      int unsigned depth;
      int unsigned r;
      bit          rec;
      bit          cmd;
      bit          cmt;
      rec   = ($urandom_range(0, 3) == 0);
      cmd   = rec ? 1'($urandom) : 1'b0;
      cmt   = rec ? 1'($urandom) : 1'b1;
      depth = 0;
      repeat ($urandom_range(0, 3)) text_buf.push_back(blank_char());
      r = $urandom_range(0, 99);
      if (r < 8) begin
         // broken opener attempt: a random character, or a slash and a random character
         if (r >= 4) text_buf.push_back(CH_SLASH);
         text_buf.push_back(pick_char());
         send_text(rec, cmd, cmt, 1'($urandom));
         return;
      end
      text_buf.push_back(CH_SLASH);
      text_buf.push_back(CH_STAR);
      repeat ($urandom_range(0, 14)) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            text_buf.push_back(CH_SLASH);
            text_buf.push_back(CH_STAR);
            depth++;
         end else if (r < 30 && depth > 0) begin
            text_buf.push_back(CH_STAR);
            text_buf.push_back(CH_SLASH);
            depth--;
         end else begin
            text_buf.push_back(pick_char());
         end
      end
      r = $urandom_range(0, 99);
      if (r < 12) begin
         // end of input inside the comment
         send_text(rec, cmd, cmt, 1'b1);
         return;
      end
      repeat (depth + 1) begin
         text_buf.push_back(CH_STAR);
         text_buf.push_back(CH_SLASH);
      end
      // a trailing character lands on an idle scanner
      if (r < 30) text_buf.push_back(pick_char());
      send_text(rec, cmd, cmt, r >= 30 && r < 40);
   endtask

   // Command content scan: parentheses, quoted strings with escapes, then a terminator.
   task automatic command_run();
      int unsigned     depth;
      int unsigned     r;
      logic [CH_W-1:0] quote;
      depth = 0;
      repeat ($urandom_range(0, 16)) begin
         r = $urandom_range(0, 99);
         if (r < 12) begin
            text_buf.push_back(CH_LPAREN);
            depth++;
         end else if (r < 22 && depth > 0) begin
            text_buf.push_back(CH_RPAREN);
            depth--;
         end else if (r < 32) begin
            quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            text_buf.push_back(quote);
            repeat ($urandom_range(0, 4)) begin
               if ($urandom_range(0, 3) == 0) text_buf.push_back(CH_BSLASH);
               text_buf.push_back(pick_char());
            end
            if ($urandom_range(0, 9) != 0) text_buf.push_back(quote);
         end else begin
            text_buf.push_back(pick_char());
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         send_text(1'b0, 1'b1, 1'($urandom), 1'b1);
      end else begin
         repeat (depth + 1) text_buf.push_back(CH_RPAREN);
         send_text(1'b0, 1'b1, 1'($urandom), 1'b0);
      end
   endtask

   // Unstructured requests: random starts, flags, characters and end marks.
   task automatic noise_run();
      repeat ($urandom_range(1, 6))
         send_request(char_item($urandom_range(0, 2) == 0, 1'($urandom), 1'($urandom),
                                1'($urandom),
                                $urandom_range(0, 1) ? pick_char()
                                                     : CH_W'($urandom_range(0, 1114111)),
                                $urandom_range(0, 7) == 0));
   endtask

   int unsigned send_pct[4] = '{0, 66, 0, 10};
   int unsigned recv_pct[4] = '{0, 0, 66, 10};
   int unsigned phase_start;
   int unsigned pick;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // no scan active, then a start with no acceptable token
      send_request(char_item(1'b0, 1'b0, 1'b0, 1'b0, 21'h61, 1'b0));
      send_request(char_item(1'b1, 1'b0, 1'b0, 1'b0, CH_SLASH, 1'b0));
      // plain comment with leading blanks
      text_buf = '{CH_SPACE, CH_TAB, CH_SLASH, CH_STAR, 21'h78, CH_STAR, CH_SLASH};
      send_text(1'b0, 1'b0, 1'b1, 1'b0);
      // missing opener: wrong first character, then slash without star
      text_buf = '{21'h61};
      send_text(1'b0, 1'b0, 1'b1, 1'b0);
      text_buf = '{CH_SLASH, 21'h62};
      send_text(1'b0, 1'b0, 1'b1, 1'b0);
      // end of input inside a comment
      text_buf = '{CH_SLASH, CH_STAR};
      send_text(1'b0, 1'b0, 1'b1, 1'b1);
      // end of input inside an escape, top code point as content
      text_buf = '{21'h10FFFF, CH_DQUOTE, CH_BSLASH};
      send_text(1'b0, 1'b1, 1'b0, 1'b1);
      // unmatched close with nothing consumed, then end of input at once
      text_buf = '{CH_RPAREN};
      send_text(1'b0, 1'b1, 1'b0, 1'b0);
      send_text(1'b0, 1'b1, 1'b0, 1'b1);
      // recovery beats command: comment path with the other blanks
      text_buf = '{CH_LF, CH_CR, CH_SLASH, CH_STAR, CH_STAR, CH_SLASH};
      send_text(1'b1, 1'b1, 1'b1, 1'b0);

      // deepest comment nesting, then one opener too many
      repeat (MAX_NEST + 1) begin
         text_buf.push_back(CH_SLASH);
         text_buf.push_back(CH_STAR);
      end
      send_text(1'b0, 1'b0, 1'b1, 1'b0);
      // deepest parenthesis nesting and back down to an accept
      repeat (MAX_NEST) text_buf.push_back(CH_LPAREN);
      repeat (MAX_NEST + 1) text_buf.push_back(CH_RPAREN);
      send_text(1'b0, 1'b1, 1'b0, 1'b0);
      // one parenthesis too many
      repeat (MAX_NEST + 1) text_buf.push_back(CH_LPAREN);
      send_text(1'b0, 1'b1, 1'b0, 1'b0);

      // random scans under each idling pattern
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         phase_start    = requests_sent;
         while (requests_sent - phase_start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
               comment_run();
            else if (pick < 80)
               command_run();
            else
               noise_run();
         end
      end

      // drain: drop valid at the last accepting edge, wait for every response
      req_tvalid <= 1'b0;
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ files.f @@
sv/nccs_pkg.sv
sv/nccs_in_reg.sv
sv/nccs_scan.sv
sv/nccs_out_reg.sv
sv/nested_comment_and_command_scanner.sv
sim/tb.sv
